// ===== design/msbh_pkg.sv =====
// msbh_pkg: types, constants and microcode program for the byte hash unit
// no dependencies; used by msbh_seq, msbh_dp, the top level and the testbench
package msbh_pkg;

	localparam logic [31:0] MIX_MULT = 32'hc6a4a793;
	localparam int MIX_SHIFT = 24;
	localparam int FIN_SHIFT_A = 13;
	localparam int FIN_SHIFT_B = 15;
	localparam int MAX_KEY_LENGTH_DEF = 65535;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_SEED = '0;

	localparam int PC_W = 4;

	typedef enum logic [2:0] {
		OPA_LEN,
		OPA_WORD,
		OPA_PART,
		OPA_KSH,
		OPA_HXK,
		OPA_HSH
	} opa_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_K,
		DST_H,
		DST_HSEED,
		DST_HXK,
		DST_PART,
		DST_OUT
	} dst_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_LENZ,
		C_POS3,
		C_NLAST,
		C_NOTAIL
	} cond_t;

	typedef struct packed {
		opa_t            opa;
		dst_t            dst;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            fin;
	} uword_t;

	typedef struct packed {
		logic load;
		opa_t opa;
		dst_t dst;
	} ctrl_t;

	typedef struct packed {
		logic first;
		logic len_zero;
		logic pos3;
		logic last;
		logic no_tail;
		logic out_busy;
	} stat_t;

	localparam logic [PC_W-1:0] PC_START = 4'd0;
	localparam logic [PC_W-1:0] PC_BYTE  = 4'd1;
	localparam logic [PC_W-1:0] PC_CHK   = 4'd2;
	localparam logic [PC_W-1:0] PC_CHK2  = 4'd3;
	localparam logic [PC_W-1:0] PC_T0    = 4'd4;
	localparam logic [PC_W-1:0] PC_T1    = 4'd5;
	localparam logic [PC_W-1:0] PC_T2    = 4'd6;
	localparam logic [PC_W-1:0] PC_W1    = 4'd7;
	localparam logic [PC_W-1:0] PC_W2    = 4'd8;
	localparam logic [PC_W-1:0] PC_FIN0  = 4'd9;
	localparam logic [PC_W-1:0] PC_FIN1  = 4'd10;

	// jump taken: target, or idle when fin is set; otherwise next step
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			PC_START: w = '{OPA_LEN,  DST_HSEED, C_LENZ,   PC_FIN0,  1'b0};
			PC_BYTE:  w = '{OPA_WORD, DST_PART,  C_POS3,   PC_W1,    1'b0};
			PC_CHK:   w = '{OPA_LEN,  DST_NONE,  C_NLAST,  PC_START, 1'b1};
			PC_CHK2:  w = '{OPA_LEN,  DST_NONE,  C_NOTAIL, PC_FIN0,  1'b0};
			PC_T0:    w = '{OPA_PART, DST_K,     C_NEVER,  PC_START, 1'b0};
			PC_T1:    w = '{OPA_KSH,  DST_K,     C_NEVER,  PC_START, 1'b0};
			PC_T2:    w = '{OPA_LEN,  DST_HXK,   C_ALWAYS, PC_FIN0,  1'b0};
			PC_W1:    w = '{OPA_KSH,  DST_K,     C_NEVER,  PC_START, 1'b0};
			PC_W2:    w = '{OPA_HXK,  DST_H,     C_ALWAYS, PC_CHK,   1'b0};
			PC_FIN0:  w = '{OPA_HSH,  DST_H,     C_NEVER,  PC_START, 1'b0};
			PC_FIN1:  w = '{OPA_LEN,  DST_OUT,   C_ALWAYS, PC_START, 1'b1};
			default:  w = '{OPA_LEN,  DST_NONE,  C_ALWAYS, PC_START, 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== design/msbh_seq.sv =====
// msbh_seq: step counter and microcode sequencer of the byte hash unit
// depends on msbh_pkg
module msbh_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  msbh_pkg::stat_t stat,
	output msbh_pkg::ctrl_t ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	logic [msbh_pkg::PC_W-1:0] pc_q;
	msbh_pkg::uword_t uw;
	logic cond_hit;
	logic stall;
	logic accept;

	assign uw = msbh_pkg::ucode(pc_q);
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign stall = (uw.dst == msbh_pkg::DST_OUT) && stat.out_busy;

	always_comb begin
		case (uw.cond)
			msbh_pkg::C_NEVER:  cond_hit = 1'b0;
			msbh_pkg::C_ALWAYS: cond_hit = 1'b1;
			msbh_pkg::C_LENZ:   cond_hit = stat.len_zero;
			msbh_pkg::C_POS3:   cond_hit = stat.pos3;
			msbh_pkg::C_NLAST:  cond_hit = !stat.last;
			msbh_pkg::C_NOTAIL: cond_hit = stat.no_tail;
			default:            cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		ctrl.load = accept;
		ctrl.opa = uw.opa;
		ctrl.dst = (state_q == ST_RUN && !stall) ? uw.dst : msbh_pkg::DST_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= msbh_pkg::PC_START;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						pc_q <= stat.first ? msbh_pkg::PC_START : msbh_pkg::PC_BYTE;
					end
				end
				ST_RUN: begin
					if (!stall) begin
						if (cond_hit) begin
							if (uw.fin) begin
								state_q <= ST_IDLE;
							end else begin
								pc_q <= uw.target;
							end
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/msbh_dp.sv =====
// msbh_dp: hash datapath with one shared 32-bit multiplier and the result register
// depends on msbh_pkg; driven by msbh_seq
module msbh_dp #(
	parameter int MAX_KEY_LENGTH = msbh_pkg::MAX_KEY_LENGTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msbh_pkg::ctrl_t ctrl,
	output msbh_pkg::stat_t stat,
	input  logic [31:0]     seed,
	input  logic [7:0]      data_byte,
	input  logic [15:0]     key_length,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [31:0]     hash_value
);

	localparam int LEN_CLOG = $clog2(64'(MAX_KEY_LENGTH) + 64'd1);
	localparam int LEN_W = (LEN_CLOG > 16) ? 16 : ((LEN_CLOG < 2) ? 2 : LEN_CLOG);

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] count_q;
	logic [23:0]      partial_q;
	logic [31:0]      k_q;
	logic [31:0]      h_q;
	logic             valid_q;
	logic [31:0]      out_q;
	logic [31:0]      mul_in;
	logic [31:0]      prod;
	logic [LEN_W-1:0] len_clamped;
	logic [1:0]       pos;

	assign pos = count_q[1:0];
	assign len_clamped = (32'(key_length) > 32'(MAX_KEY_LENGTH)) ?
		LEN_W'(MAX_KEY_LENGTH) : LEN_W'(key_length);

	always_comb begin
		case (ctrl.opa)
			msbh_pkg::OPA_LEN:  mul_in = 32'(len_q);
			msbh_pkg::OPA_WORD: mul_in = {byte_q, partial_q};
			msbh_pkg::OPA_PART: mul_in = {8'h00, partial_q};
			msbh_pkg::OPA_KSH:  mul_in = k_q ^ (k_q >> msbh_pkg::MIX_SHIFT);
			msbh_pkg::OPA_HXK:  mul_in = h_q ^ k_q;
			msbh_pkg::OPA_HSH:  mul_in = h_q ^ (h_q >> msbh_pkg::FIN_SHIFT_A);
			default:            mul_in = '0;
		endcase
	end

	assign prod = mul_in * msbh_pkg::MIX_MULT;

	always_comb begin
		stat.first = (count_q == '0);
		stat.len_zero = (len_q == '0);
		stat.pos3 = (pos == 2'd3);
		stat.last = (count_q == len_q);
		stat.no_tail = (len_q[1:0] == 2'd0);
		stat.out_busy = valid_q && !res_ready;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= data_byte;
		end
		case (ctrl.dst) inside
			msbh_pkg::DST_K, msbh_pkg::DST_PART: k_q <= prod;
			msbh_pkg::DST_OUT: out_q <= h_q ^ (h_q >> msbh_pkg::FIN_SHIFT_B);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			count_q <= '0;
			partial_q <= '0;
			h_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ctrl.load && count_q == '0) begin
				len_q <= len_clamped;
				partial_q <= '0;
			end
			case (ctrl.dst)
				msbh_pkg::DST_H:     h_q <= prod;
				msbh_pkg::DST_HSEED: h_q <= seed ^ prod;
				msbh_pkg::DST_HXK:   h_q <= h_q ^ k_q;
				msbh_pkg::DST_PART: begin
					count_q <= count_q + 1'b1;
					case (pos)
						2'd0: partial_q[7:0] <= byte_q;
						2'd1: partial_q[15:8] <= byte_q;
						2'd2: partial_q[23:16] <= byte_q;
						default: partial_q <= '0;
					endcase
				end
				msbh_pkg::DST_OUT: begin
					count_q <= '0;
					partial_q <= '0;
				end
				default: ;
			endcase
			if (ctrl.dst == msbh_pkg::DST_OUT) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = valid_q;
	assign hash_value = out_q;

endmodule

// ===== design/murmur_style_byte_hash_unit.sv =====
// murmur_style_byte_hash_unit: top level, stream ports, seed register on an APB port
// depends on msbh_pkg, msbh_seq, msbh_dp
//
// Hashes a key delivered one byte per input word into a 32-bit Murmur-style value.
// key_length is sampled on a key's first word (clamped to MAX_KEY_LENGTH); a length
// of zero yields the empty-key hash of the seed at once, ignoring the data byte.
// The seed is sampled at the start of each key. A microcoded sequencer steps one
// shared 32-bit multiplier, so the input is busy while it runs: a byte that does not
// close a word is absorbed and checked, one that closes a word is also mixed into the
// hash, the first byte of a key is preceded by seeding the hash with the length, and
// the last byte adds finalization, preceded by mixing in a 1 to 3 byte tail if any.
// The empty key runs only the seeding and finalization steps. The finished hash sits
// in an output register, so the next key byte is accepted while it waits; the final
// step waits only if that register is still occupied.
module murmur_style_byte_hash_unit #(
	parameter int MAX_KEY_LENGTH = msbh_pkg::MAX_KEY_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,  // data_byte[7:0], key_length[23:8]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // hash_value[31:0]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msbh_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [31:0] seed_q;
	msbh_pkg::ctrl_t ctrl;
	msbh_pkg::stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[msbh_pkg::APB_AW-1:2] == msbh_pkg::REG_SEED) begin
			seed_q <= pwdata;
		end
	end

	assign prdata = (paddr[msbh_pkg::APB_AW-1:2] == msbh_pkg::REG_SEED) ? seed_q : 32'h0;

	msbh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	msbh_dp #(
		.MAX_KEY_LENGTH (MAX_KEY_LENGTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.seed       (seed_q),
		.data_byte  (s_tdata[7:0]),
		.key_length (s_tdata[23:8]),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.hash_value (m_tdata)
	);

endmodule

// ===== design/msbh_checker.sv =====
// msbh_checker: port-level assertions for the byte hash unit, bound to the top level
// depends on murmur_style_byte_hash_unit
module msbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// every accepted word puts the sequencer into its running state, so input ready drops
	a_busy_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a word was taken");

	// a new result only comes out of a running program
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the sequencer was idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	a_out_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result withdrawn without being taken");

endmodule

bind murmur_style_byte_hash_unit msbh_checker u_msbh_checker (.*);

// ===== dv/tb.sv =====
// tb: self-checking stream testbench for murmur_style_byte_hash_unit
// predicts each key hash from the accepted bytes and the seed register, checks every word
// depends on msbh_pkg and murmur_style_byte_hash_unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [23:0]                   s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [31:0]                   m_tdata;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [msbh_pkg::APB_AW-1:0]   paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;

	murmur_style_byte_hash_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// key bytes waiting to be sent, packed as {key_length, data_byte}
	logic [23:0] key_bytes_q[$];
	logic [31:0] hash_exp_q[$];

	logic [31:0] seed_val;
	logic [31:0] acc_hash;
	logic [23:0] part_bytes;
	logic [15:0] taken_cnt;
	logic [15:0] key_len;

	int s_idle_pct;
	int m_idle_pct;
	int s_gap;
	int m_stall;
	int fails;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] mix_k(input logic [31:0] k);
		logic [31:0] t;
		t = k * msbh_pkg::MIX_MULT;
		t = t ^ (t >> msbh_pkg::MIX_SHIFT);
		t = t * msbh_pkg::MIX_MULT;
		return t;
	endfunction

	function automatic logic [31:0] finalize_hash(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> msbh_pkg::FIN_SHIFT_A);
		t = t * msbh_pkg::MIX_MULT;
		t = t ^ (t >> msbh_pkg::FIN_SHIFT_B);
		return t;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(99) < 85)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	task automatic absorb_byte(input logic [23:0] w);
		logic [7:0]  b;
		logic [15:0] len;
		logic [1:0]  pos;
		b = w[7:0];
		len = w[23:8];
		if (taken_cnt == 16'd0) begin
			key_len = len;
			acc_hash = seed_val ^ (32'(len) * msbh_pkg::MIX_MULT);
			part_bytes = '0;
			if (len == 16'd0) begin
				hash_exp_q.push_back(finalize_hash(acc_hash));
				return;
			end
		end
		pos = taken_cnt[1:0];
		if (pos == 2'd3) begin
			acc_hash = (acc_hash ^ mix_k({b, part_bytes})) * msbh_pkg::MIX_MULT;
			part_bytes = '0;
		end else begin
			part_bytes[8*pos +: 8] = b;
		end
		taken_cnt = taken_cnt + 16'd1;
		if (taken_cnt == key_len) begin
			if (key_len[1:0] != 2'd0)
				acc_hash = acc_hash ^ mix_k({8'h00, part_bytes});
			hash_exp_q.push_back(finalize_hash(acc_hash));
			taken_cnt = '0;
			part_bytes = '0;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_gap = s_gap - 1;
					s_tvalid <= 1'b0;
				end else if (key_bytes_q.size() != 0) begin
					s_tdata <= key_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_gap = ($urandom_range(99) < s_idle_pct) ? gap_len() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (hash_exp_q.size() == 0) begin
					$error("hash_value: unexpected word, actual %h", m_tdata);
					fails++;
				end else if (m_tdata !== hash_exp_q[0]) begin
					$error("hash_value mismatch: expected %h, actual %h", hash_exp_q[0], m_tdata);
					fails++;
					void'(hash_exp_q.pop_front());
				end else begin
					void'(hash_exp_q.pop_front());
				end
			end
			if (m_stall > 0)
				m_stall = m_stall - 1;
			else if ($urandom_range(99) < m_idle_pct)
				m_stall = gap_len();
			m_tready <= (m_stall == 0);
		end
	end

	task automatic add_key(input int len, input bit extremes);
		logic [7:0]  b;
		logic [15:0] kl;
		for (int i = 0; i < ((len == 0) ? 1 : len); i++) begin
			if (extremes)
				b = (i % 2 == 0) ? 8'hff : 8'h00;
			else if ($urandom_range(9) == 0)
				b = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
			else
				b = 8'($urandom_range(255));
			kl = (i == 0) ? 16'(len) : 16'($urandom_range(16'hffff));
			key_bytes_q.push_back({kl, b});
		end
	endtask

	task automatic random_keys(input int n_bytes);
		int r;
		int len;
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(99);
			if (r < 10)
				len = 0;
			else if (r < 80)
				len = $urandom_range(12, 1);
			else
				len = $urandom_range(64, 13);
			add_key(len, 1'b0);
			sent += (len == 0) ? 1 : len;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (key_bytes_q.size() != 0 || s_tvalid || hash_exp_q.size() != 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {msbh_pkg::REG_SEED, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seed_val = v;
	endtask

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		seed_val = '0;
		acc_hash = '0;
		part_bytes = '0;
		taken_cnt = '0;
		key_len = '0;
		s_idle_pct = 30;
		m_idle_pct = 30;
		fails = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed keys on the reset seed: empty keys, short keys, every tail size
		add_key(0, 1'b1);
		key_bytes_q.push_back({16'h0000, 8'h00});
		add_key(1, 1'b1);
		add_key(2, 1'b1);
		add_key(3, 1'b1);
		add_key(4, 1'b1);
		add_key(5, 1'b1);
		wait_drained();

		write_seed(32'hffff_ffff);
		add_key(0, 1'b1);
		add_key(4, 1'b1);
		add_key(7, 1'b0);
		wait_drained();

		write_seed(32'h8000_0000);
		s_idle_pct = 0;
		m_idle_pct = 0;
		random_keys(160);
		wait_drained();

		write_seed(32'($urandom));
		s_idle_pct = 30;
		m_idle_pct = 30;
		random_keys(160);
		wait_drained();

		write_seed(32'h0000_0001);
		s_idle_pct = 60;
		m_idle_pct = 10;
		random_keys(160);
		wait_drained();

		write_seed(32'($urandom));
		s_idle_pct = 10;
		m_idle_pct = 70;
		random_keys(160);
		wait_drained();

		write_seed(32'h0000_0000);
		s_idle_pct = 25;
		m_idle_pct = 25;
		random_keys(100);
		wait_drained();

		// one longer key and a short one, sent back to back
		write_seed(32'($urandom));
		s_idle_pct = 0;
		m_idle_pct = 50;
		add_key(20, 1'b0);
		add_key(3, 1'b0);
		wait_drained();

		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
